/* rtl/salp_pkg.sv */
// Shared constants and types of the sensor array line position block.
// No dependencies; every other file of the block imports this package.
package salp_pkg;

   // Field widths of the channels and the configuration port.
   localparam int SAMPLE_W   = 12;
   localparam int POS_W      = 16;
   localparam int COUNT_W    = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // Serial arithmetic: samples are multiplied one digit per cycle.
   localparam int DIGIT_W = 4;
   localparam int DIGITS  = SAMPLE_W / DIGIT_W;

   // Q1.15 output format.
   localparam int FRAC_W  = 15;
   localparam int Q15_ONE = 32768;
   localparam int Q15_MAX = 32767;

   localparam int MAX_SENSORS_DEF = 16;

   // Register reset values.
   localparam logic [SAMPLE_W-1:0] BOUND_A_RESET = 12'd0;
   localparam logic [SAMPLE_W-1:0] BOUND_B_RESET = 12'd4095;
   localparam logic                DARK_RESET    = 1'b1;
   localparam logic [COUNT_W-1:0]  COUNT_RESET   = 5'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOUND_A      = 2'd0,
      CSR_BOUND_B      = 2'd1,
      CSR_LINE_IS_DARK = 2'd2,
      CSR_SENSOR_COUNT = 2'd3
   } csr_index_type;

endpackage

/* rtl/salp_req_if.sv */
// Sample channel of the line position block: valid/ready with one raw sample.
// Depends on salp_pkg for the sample width.
interface salp_req_if import salp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

/* rtl/salp_rsp_if.sv */
// Result channel of the line position block: valid/ready with one position.
// Depends on salp_pkg for the position width.
interface salp_rsp_if import salp_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] position;

   modport source (output valid, output position, input ready);
   modport sink (input valid, input position, output ready);
endinterface

/* rtl/salp_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle, NUM_W bits in all.
// Depends on salp_pkg only through the common import convention.
module salp_div import salp_pkg::*; #(
   parameter int NUM_W = 36,
   parameter int DEN_W = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num_in,
   input  logic [DEN_W-1:0] den_in,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   rem_sh;
   logic [DEN_W+1:0] diff;

   // The quotient register starts out holding the numerator; each step moves
   // its top bit into the remainder and a quotient bit in at the bottom.
   assign rem_sh = {rem_ff, quo_ff[NUM_W-1]};
   assign diff   = {1'b0, rem_sh} - {2'b00, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = num_in;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (diff[DEN_W+1]) begin
            rem_in = rem_sh[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end else begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         den_ff <= den_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/sensor_array_line_position_top.sv */
// Top level of the sensor array line position block (weighted centroid).
// Depends on salp_pkg, salp_req_if, salp_rsp_if and salp_div.
//
// Usage:
//   req_ch carries one raw sample per item, in sensor order; rsp_ch carries
//   one Q1.15 position per completed frame of sensor_count samples, the
//   count saturated to 2..MAX_SENSORS. Both use valid/ready; an item moves
//   at a clock edge where both are high.
//   The csr_ port writes bound_a, bound_b, line_is_dark and sensor_count by
//   index; a write applies from the next sample on, also in mid-frame.
//   Each sample is remapped in its accept cycle, then multiplied by its
//   sensor weight one 4-bit digit at a time; no sample is taken meanwhile.
//   After the last sample of a frame the divisor product is formed and a
//   bit-serial divider produces one quotient bit per cycle over NUM_W =
//   15 + 13 + 2*clog2(MAX_SENSORS) bits (36 for 16 sensors). No sample is
//   taken until the position has moved into the output register.
//   The result sits in an output register, so the next frame's samples are
//   taken while it waits; a new result waits for that register to be free.
//   Synchronous reset loads the register defaults, clears the frame index and
//   both sums and empties the output register.
module sensor_array_line_position_top import salp_pkg::*; #(
   parameter int MAX_SENSORS = MAX_SENSORS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   salp_req_if.sink              req_ch,
   salp_rsp_if.source            rsp_ch,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int IDX_W  = $clog2(MAX_SENSORS);
   localparam int CNT_W  = $clog2(MAX_SENSORS + 1);
   localparam int SAT_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int WT_W   = IDX_W + 1;
   localparam int P_W    = WT_W + SAMPLE_W;
   localparam int WSUM_W = SAMPLE_W + 1 + 2 * IDX_W;
   localparam int SUM_W  = SAMPLE_W + IDX_W;
   localparam int DEN_W  = SUM_W + IDX_W;
   localparam int NUM_W  = WSUM_W + FRAC_W;
   localparam int DIG_W  = $clog2(DIGITS);
   localparam int PROD_W = WT_W + DIGIT_W + 1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DIGIT = 5'b00010,
      ST_CLOSE = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_PUSH  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [SAMPLE_W-1:0] bound_a_ff, bound_b_ff;
   logic                dark_ff;
   logic [COUNT_W-1:0]  count_ff;

   logic [IDX_W-1:0]         index_ff, index_in;
   logic signed [WSUM_W-1:0] wsum_ff, wsum_in;
   logic [SUM_W-1:0]         ssum_ff, ssum_in;
   logic [DIG_W-1:0]         dig_ff, dig_in;
   logic                     last_ff;
   logic [IDX_W-1:0]         half_ff;
   logic [SAMPLE_W-1:0]      v_ff, v_sr_ff;
   logic signed [WT_W-1:0]   w_ff;
   logic signed [P_W-1:0]    p_ff, p_in;
   logic                     neg_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0]  rsp_pos_ff;

   logic                accept;
   logic [SAT_W-1:0]    count_wide, n_sat;
   logic [CNT_W-1:0]    n_eff;
   logic [IDX_W-1:0]    half;
   logic                last;
   logic signed [WT_W-1:0] weight;
   logic [SAMPLE_W-1:0] lo, hi, clamped, shifted, v_new;
   logic [DIGIT_W-1:0]  digit;
   logic signed [PROD_W-1:0] prod;
   logic [WSUM_W-1:0]   w_mag;
   logic [SUM_W-1:0]    s_eff;
   logic [DEN_W-1:0]    den;
   logic [NUM_W-1:0]    num;
   logic                div_done;
   logic [NUM_W-1:0]    quotient;
   logic                rsp_free;
   logic signed [POS_W-1:0] pos_sat;

   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   // Effective count, saturated to the supported range.
   always_comb begin
      count_wide = SAT_W'(count_ff);
      if (count_wide < SAT_W'(2)) begin
         n_sat = SAT_W'(2);
      end else if (count_wide > SAT_W'(MAX_SENSORS)) begin
         n_sat = SAT_W'(MAX_SENSORS);
      end else begin
         n_sat = count_wide;
      end
   end
   assign n_eff  = CNT_W'(n_sat);
   assign half   = IDX_W'(n_eff >> 1);
   assign last   = ((IDX_W + 1)'(index_ff) + 1'b1) >= (IDX_W + 1)'(n_eff);
   assign weight = $signed({1'b0, index_ff}) - $signed({1'b0, half});

   // Clamp to the ordered bounds, shift down and optionally invert.
   always_comb begin
      lo = (bound_a_ff < bound_b_ff) ? bound_a_ff : bound_b_ff;
      hi = (bound_a_ff < bound_b_ff) ? bound_b_ff : bound_a_ff;
      clamped = req_ch.sample;
      if (clamped < lo) begin
         clamped = lo;
      end
      if (clamped > hi) begin
         clamped = hi;
      end
      shifted = clamped - lo;
      v_new = dark_ff ? ((hi - lo) - shifted) : shifted;
   end

   // Horner product over the sample digits, most significant digit first.
   assign digit = v_sr_ff[SAMPLE_W-1 -: DIGIT_W];
   assign prod  = w_ff * $signed({1'b0, digit});
   assign p_in  = (p_ff <<< DIGIT_W) + P_W'(prod);

   assign w_mag = wsum_ff[WSUM_W-1] ? WSUM_W'(-wsum_ff) : WSUM_W'(wsum_ff);
   assign num   = {w_mag, FRAC_W'(0)};
   assign s_eff = (ssum_ff == '0) ? SUM_W'(1) : ssum_ff;
   assign den   = DEN_W'(s_eff) * DEN_W'(half_ff);

   salp_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_CLOSE),
      .num_in   (num),
      .den_in   (den),
      .done     (div_done),
      .quotient (quotient)
   );

   // Saturate the magnitude quotient and apply the sign.
   always_comb begin
      if (neg_ff) begin
         if (quotient > NUM_W'(Q15_ONE)) begin
            pos_sat = $signed(POS_W'(Q15_ONE));
         end else begin
            pos_sat = $signed(-quotient[POS_W-1:0]);
         end
      end else begin
         if (quotient > NUM_W'(Q15_MAX)) begin
            pos_sat = $signed(POS_W'(Q15_MAX));
         end else begin
            pos_sat = $signed(quotient[POS_W-1:0]);
         end
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in     = state_ff;
      index_in     = index_ff;
      wsum_in      = wsum_ff;
      ssum_in      = ssum_ff;
      dig_in       = dig_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               index_in = last ? '0 : IDX_W'(index_ff + 1'b1);
               dig_in   = '0;
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            dig_in = dig_ff + 1'b1;
            if (dig_ff == DIG_W'(DIGITS - 1)) begin
               wsum_in  = wsum_ff + WSUM_W'(p_in);
               ssum_in  = ssum_ff + SUM_W'(v_ff);
               state_in = last_ff ? ST_CLOSE : ST_IDLE;
            end
         end
         ST_CLOSE: begin
            // The divider has taken both operands; the sums start over.
            wsum_in  = '0;
            ssum_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         index_ff     <= '0;
         wsum_ff      <= '0;
         ssum_ff      <= '0;
         dig_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         bound_a_ff   <= BOUND_A_RESET;
         bound_b_ff   <= BOUND_B_RESET;
         dark_ff      <= DARK_RESET;
         count_ff     <= COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         index_ff     <= index_in;
         wsum_ff      <= wsum_in;
         ssum_ff      <= ssum_in;
         dig_ff       <= dig_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               CSR_BOUND_A:      bound_a_ff <= csr_write_data;
               CSR_BOUND_B:      bound_b_ff <= csr_write_data;
               CSR_LINE_IS_DARK: dark_ff    <= csr_write_data[0];
               CSR_SENSOR_COUNT: count_ff   <= csr_write_data[COUNT_W-1:0];
               default:          dark_ff    <= dark_ff;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         v_ff    <= v_new;
         v_sr_ff <= v_new;
         w_ff    <= weight;
         last_ff <= last;
         p_ff    <= '0;
         if (last) begin
            half_ff <= half;
         end
      end else if (state_ff == ST_DIGIT) begin
         p_ff    <= p_in;
         v_sr_ff <= v_sr_ff << DIGIT_W;
      end
      if (state_ff == ST_CLOSE) begin
         neg_ff <= wsum_ff[WSUM_W-1];
      end
      if (state_ff == ST_PUSH && rsp_free) begin
         rsp_pos_ff <= pos_sat;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.position = rsp_pos_ff;

endmodule

/* sim/salp_position_checker.sv */
// Checker of the sensor array line position block: watches the sample, result and
// register ports, predicts each frame's position and compares it with the result.
// Depends on salp_pkg and the salp_req_if and salp_rsp_if channel interfaces.
module salp_position_checker import salp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   salp_req_if                   req_mon,
   salp_rsp_if                   rsp_mon,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output int                    failures,
   output int                    pending_positions,
   output int                    positions_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SENSOR_LIMIT = MAX_SENSORS_DEF;

   logic [SAMPLE_W-1:0]     bound_a;
   logic [SAMPLE_W-1:0]     bound_b;
   logic                    line_is_dark;
   logic [COUNT_W-1:0]      sensor_count;
   int                      frame_index;
   longint                  weighted_acc;
   longint                  strength_acc;
   logic signed [POS_W-1:0] expected_positions[$];

   // Adds one sample to the running frame and, on its last sample, queues the
   // position that the block must report.
   task automatic absorb_sample(input logic [SAMPLE_W-1:0] raw);
      int     n;
      int     half;
      int     lo;
      int     hi;
      int     v;
      longint den;
      longint quotient;
      n = sensor_count;
      if (n < 2) n = 2;
      if (n > SENSOR_LIMIT) n = SENSOR_LIMIT;
      half = n / 2;
      lo = (bound_a < bound_b) ? bound_a : bound_b;
      hi = (bound_a < bound_b) ? bound_b : bound_a;
      v = raw;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      v = v - lo;
      if (line_is_dark) v = (hi - lo) - v;
      weighted_acc += longint'(frame_index - half) * v;
      strength_acc += v;
      if (frame_index + 1 < n) begin
         frame_index++;
      end else begin
         den = ((strength_acc == 0) ? 64'sd1 : strength_acc) * half;
         // Signed division truncates toward zero, as the block does.
         quotient = (weighted_acc * Q15_ONE) / den;
         if (quotient > Q15_MAX) quotient = Q15_MAX;
         if (quotient < -Q15_ONE) quotient = -Q15_ONE;
         expected_positions.push_back(quotient[POS_W-1:0]);
         frame_index = 0;
         weighted_acc = 0;
         strength_acc = 0;
      end
   endtask

   always @(posedge clock) begin
      logic signed [POS_W-1:0] want;
      if (reset) begin
         bound_a = BOUND_A_RESET;
         bound_b = BOUND_B_RESET;
         line_is_dark = DARK_RESET;
         sensor_count = COUNT_RESET;
         frame_index = 0;
         weighted_acc = 0;
         strength_acc = 0;
         expected_positions.delete();
         failures = 0;
         positions_checked = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) absorb_sample(req_mon.sample);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_positions.size() == 0) begin
               failures++;
               $display("%0t: unexpected position, expected none actual %0d",
                        $time, rsp_mon.position);
            end else begin
               want = expected_positions.pop_front();
               positions_checked++;
               if (rsp_mon.position !== want) begin
                  failures++;
                  $display("%0t: position mismatch, expected %0d actual %0d",
                           $time, want, rsp_mon.position);
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BOUND_A:      bound_a = csr_write_data[SAMPLE_W-1:0];
               CSR_BOUND_B:      bound_b = csr_write_data[SAMPLE_W-1:0];
               CSR_LINE_IS_DARK: line_is_dark = csr_write_data[0];
               CSR_SENSOR_COUNT: sensor_count = csr_write_data[COUNT_W-1:0];
               default: ;
            endcase
         end
      end
      pending_positions = expected_positions.size();
   end

endmodule

/* sim/sensor_array_line_position_top_tb.sv */
// Testbench top of the sensor array line position block: clock, reset, sample and
// register stimulus, result back-pressure and the verdict.
// Depends on salp_pkg, the channel interfaces, the block and salp_position_checker.
module sensor_array_line_position_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import salp_pkg::*;

   localparam int RANDOM_SAMPLES = 900;
   localparam int SETTLE_CYCLES  = 60;
   localparam int TAIL_SAMPLES   = 120;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   int                    failures;
   int                    pending;
   int                    checked;
   int                    samples_sent;
   int                    settings_used;
   logic                  calm;
   logic                  quiet_tail;
   int                    stall_left;
   logic [COUNT_W-1:0]    count_setting;

   salp_req_if req_if ();
   salp_rsp_if rsp_if ();

   sensor_array_line_position_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_if),
      .rsp_ch           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   salp_position_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_if),
      .rsp_mon           (rsp_if),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .failures          (failures),
      .pending_positions (pending),
      .positions_checked (checked)
   );

   always #10 clock = ~clock;

   // Result back-pressure: short random stalls except in calm phases and the tail.
   always @(negedge clock) begin
      if (calm || quiet_tail) begin
         rsp_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_if.ready <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_sample(input logic [SAMPLE_W-1:0] raw);
      int gap;
      gap = 0;
      if (!calm && !quiet_tail && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 3);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid  <= 1'b1;
      req_if.sample <= raw;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      samples_sent++;
   endtask

   // Waits until every queued position has come back and the block is quiet.
   task automatic settle();
      req_if.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample(input int style, input int i,
                                                        input int centre);
      case (style)
         0: return SAMPLE_W'($urandom_range(0, 4095));
         1: return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
         2: begin
            // Dark line over up to three sensors on a bright floor.
            if (i >= centre - 1 && i <= centre + 1) return SAMPLE_W'($urandom_range(0, 600));
            return SAMPLE_W'($urandom_range(3200, 4095));
         end
         default: begin
            if (i >= centre - 1 && i <= centre + 1) begin
               return SAMPLE_W'($urandom_range(3400, 4095));
            end
            return SAMPLE_W'($urandom_range(0, 900));
         end
      endcase
   endfunction

   initial begin
      int directed_count;
      int eff;
      int frames;
      int style;
      int centre;
      logic [SAMPLE_W-1:0] a_val;
      logic [SAMPLE_W-1:0] b_val;
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.sample = '0;
      rsp_if.ready = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_BOUND_A;
      csr_write_data = '0;
      calm = 1'b0;
      quiet_tail = 1'b0;
      stall_left = 0;
      samples_sent = 0;
      settings_used = 1;
      count_setting = COUNT_RESET;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: a dark line under the leftmost sensor of eight.
      send_sample(12'h000);
      repeat (7) send_sample(12'hFFF);

      // Swapped bounds, bright line, two sensors; the second frame has no strength.
      settle();
      write_reg(CSR_BOUND_A, 12'd4000);
      write_reg(CSR_BOUND_B, 12'd100);
      write_reg(CSR_LINE_IS_DARK, 12'hFFE);
      write_reg(CSR_SENSOR_COUNT, 12'hFE2);
      send_sample(12'hFFF);
      send_sample(12'h000);
      send_sample(12'h000);
      send_sample(12'h000);

      // A count of zero behaves as two sensors.
      settle();
      write_reg(CSR_SENSOR_COUNT, 12'hAE0);
      send_sample(12'd50);
      send_sample(12'hFFF);

      // Equal bounds with a count of one.
      settle();
      write_reg(CSR_BOUND_A, 12'h800);
      write_reg(CSR_BOUND_B, 12'h800);
      write_reg(CSR_SENSOR_COUNT, 12'h541);
      send_sample(12'h7FF);
      send_sample(12'h801);

      // Mid-frame change: a moved bound and a count below the index close the frame.
      settle();
      write_reg(CSR_BOUND_A, 12'h000);
      write_reg(CSR_BOUND_B, 12'hFFF);
      write_reg(CSR_LINE_IS_DARK, 12'h001);
      write_reg(CSR_SENSOR_COUNT, 12'd8);
      repeat (5) send_sample(SAMPLE_W'($urandom_range(0, 4095)));
      settle();
      write_reg(CSR_BOUND_A, 12'd2000);
      write_reg(CSR_SENSOR_COUNT, 12'd3);
      send_sample(SAMPLE_W'($urandom_range(0, 4095)));
      directed_count = samples_sent;
      settings_used += 5;

      // Random phases, each under one register setting and made of whole frames.
      while (samples_sent < directed_count + RANDOM_SAMPLES) begin
         settle();
         settings_used++;
         case ($urandom_range(0, 4))
            0: begin a_val = 12'h000; b_val = 12'hFFF; end
            1: begin a_val = 12'hFFF; b_val = 12'h000; end
            2: begin a_val = SAMPLE_W'($urandom_range(0, 4095)); b_val = a_val; end
            default: begin
               a_val = SAMPLE_W'($urandom_range(0, 4095));
               b_val = SAMPLE_W'($urandom_range(0, 4095));
            end
         endcase
         case ($urandom_range(0, 5))
            0: count_setting = 5'd2;
            1: count_setting = 5'd16;
            2: count_setting = COUNT_W'($urandom_range(0, 1) ? $urandom_range(0, 1)
                                                             : $urandom_range(17, 31));
            default: count_setting = COUNT_W'($urandom_range(2, 16));
         endcase
         if (settings_used == 7 || $urandom_range(0, 1)) write_reg(CSR_BOUND_A, a_val);
         if (settings_used == 7 || $urandom_range(0, 1)) write_reg(CSR_BOUND_B, b_val);
         if (settings_used == 7 || $urandom_range(0, 1))
            write_reg(CSR_LINE_IS_DARK, CSR_DATA_W'($urandom_range(0, 4095)));
         write_reg(CSR_SENSOR_COUNT,
                   {(CSR_DATA_W - COUNT_W)'($urandom_range(0, 127)), count_setting});
         eff = count_setting < 2 ? 2 : (count_setting > 16 ? 16 : count_setting);
         calm <= ($urandom_range(0, 3) == 0);
         frames = $urandom_range(2, 8);
         repeat (frames) begin
            style = $urandom_range(0, 5);
            centre = $urandom_range(0, eff - 1);
            for (int i = 0; i < eff; i++) send_sample(pick_sample(style, i, centre));
            if (samples_sent >= directed_count + RANDOM_SAMPLES - TAIL_SAMPLES)
               quiet_tail <= 1'b1;
         end
      end

      settle();
      $display("Sent %0d samples under %0d register settings, %0d positions compared.",
               samples_sent, settings_used, checked);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #(10ms);
      $display("Regression FAIL");
      $finish;
   end

endmodule

/* files.f */
rtl/salp_pkg.sv
rtl/salp_req_if.sv
rtl/salp_rsp_if.sv
rtl/salp_div.sv
rtl/sensor_array_line_position_top.sv
sim/salp_position_checker.sv
sim/sensor_array_line_position_top_tb.sv
